@@ design/tcpqs_pkg.sv @@
// Shared types, constants and the microprogram of the two-class priority queue server.
package tcpqs_pkg;

   // Default sizes of the server
   localparam int QUEUE_DEPTH_DEF  = 64;
   localparam int MAX_ARRIVALS_DEF = 15;
   localparam int TIME_BITS_DEF    = 32;

   // Fixed field widths of the streams
   localparam int ARR_W    = 4;
   localparam int WAIT_W   = 32;
   localparam int LEN_W    = 7;
   localparam int STEP_W   = 3;

   typedef logic [STEP_W-1:0] step_type;

   // Microprogram addresses
   localparam step_type STEP_IDLE      = 3'd0;
   localparam step_type STEP_SERVE     = 3'd1;
   localparam step_type STEP_PUSH_HIGH = 3'd2;
   localparam step_type STEP_PUSH_LOW  = 3'd3;
   localparam step_type STEP_EMIT      = 3'd4;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_LATCH,
      ACT_POP,
      ACT_PUSH_HIGH,
      ACT_PUSH_LOW,
      ACT_EMIT
   } action_type;

   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_ACCEPT,
      COND_PUSH_HIGH,
      COND_PUSH_LOW,
      COND_OUT_FREE
   } cond_type;

   // One control word: take target_true when the condition holds, else target_false
   typedef struct packed {
      action_type action;
      cond_type   cond;
      step_type   target_true;
      step_type   target_false;
   } ucode_type;

   // Datapath conditions sampled by the sequencer
   typedef struct packed {
      logic accept;
      logic can_push_high;
      logic can_push_low;
      logic out_free;
   } status_type;

   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type word;
      case (step)
         STEP_IDLE:      word = '{ACT_LATCH, COND_ACCEPT, STEP_SERVE, STEP_IDLE};
         STEP_SERVE:     word = '{ACT_POP, COND_ALWAYS, STEP_PUSH_HIGH, STEP_PUSH_HIGH};
         STEP_PUSH_HIGH: word = '{ACT_PUSH_HIGH, COND_PUSH_HIGH, STEP_PUSH_HIGH,
                                  STEP_PUSH_LOW};
         STEP_PUSH_LOW:  word = '{ACT_PUSH_LOW, COND_PUSH_LOW, STEP_PUSH_LOW, STEP_EMIT};
         STEP_EMIT:      word = '{ACT_EMIT, COND_OUT_FREE, STEP_IDLE, STEP_EMIT};
         default:        word = '{ACT_NONE, COND_ALWAYS, STEP_IDLE, STEP_IDLE};
      endcase
      return word;
   endfunction

endpackage

@@ design/tcpqs_sequencer.sv @@
// Step counter and control-word store of the priority queue server.
module tcpqs_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  tcpqs_pkg::status_type  status,
   output tcpqs_pkg::ucode_type   ucode
);

   tcpqs_pkg::step_type step_ff;
   tcpqs_pkg::step_type step_in;
   logic                taken;

   always_comb begin
      ucode = tcpqs_pkg::ucode_rom(step_ff);
   end

   always_comb begin
      case (ucode.cond)
         tcpqs_pkg::COND_ALWAYS:    taken = 1'b1;
         tcpqs_pkg::COND_ACCEPT:    taken = status.accept;
         tcpqs_pkg::COND_PUSH_HIGH: taken = status.can_push_high;
         tcpqs_pkg::COND_PUSH_LOW:  taken = status.can_push_low;
         tcpqs_pkg::COND_OUT_FREE:  taken = status.out_free;
         default:                   taken = 1'b1;
      endcase
      step_in = taken ? ucode.target_true : ucode.target_false;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= tcpqs_pkg::STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

@@ design/two_class_priority_queue_server.sv @@
// Top level of the two-class strict-priority slotted queue server.
//
//  channel | direction | handshake                | contents
//  --------+-----------+--------------------------+----------------------------------------
//  req     | in        | req_tvalid / req_tready  | one time slot: availability, arrivals
//  rsp     | out       | rsp_tvalid / rsp_tready  | service flags, wait, lengths, drops
//
// A slot is latched and served, then the stamps actually taken are pushed into the high and
// then the low queue (each at most MAX_ARRIVALS) before the result of the slot is emitted.
// Pushes are paced by the single write port of each stamp memory: one push a cycle.
// Reset (synchronous, active high) empties both queues, zeroes the slot counter and
// drops any waiting result transaction; stamp memories are not cleared.
// A stalled result holds in the output register; the sequencer waits in its last step
// until the register frees, and a new slot is taken only once the previous one is emitted.
module two_class_priority_queue_server #(
   parameter int QUEUE_DEPTH  = tcpqs_pkg::QUEUE_DEPTH_DEF,
   parameter int MAX_ARRIVALS = tcpqs_pkg::MAX_ARRIVALS_DEF,
   parameter int TIME_BITS    = tcpqs_pkg::TIME_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [0] server_available, [4:1] arrivals_high, [8:5] arrivals_low, [15:9] zero
   input  logic [15:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [31:0] wait_slots, [38:32] length_high, [45:39] length_low,
   // [49:46] dropped_high, [53:50] dropped_low, [55:54] zero
   output logic [55:0] rsp_tdata,
   // [0] served_high, [1] served_low
   output logic [1:0]  rsp_tuser
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int ARR_W = tcpqs_pkg::ARR_W;

   typedef logic [PTR_W-1:0]     ptr_type;
   typedef logic [CNT_W-1:0]     cnt_type;
   typedef logic [TIME_BITS-1:0] stamp_type;
   typedef logic [ARR_W-1:0]     arr_type;

   tcpqs_pkg::ucode_type  ucode;
   tcpqs_pkg::status_type status;

   // Stamp memories, one per class
   stamp_type high_mem [QUEUE_DEPTH];
   stamp_type low_mem  [QUEUE_DEPTH];
   stamp_type high_q_ff, low_q_ff;

   // Latched slot request
   logic    avail_ff, avail_in;
   arr_type arr_high_ff, arr_high_in, arr_low_ff, arr_low_in;
   arr_type left_high_ff, left_high_in, left_low_ff, left_low_in;
   arr_type pushed_high_ff, pushed_high_in, pushed_low_ff, pushed_low_in;
   logic    serve_high_ff, serve_high_in, serve_low_ff, serve_low_in;

   // Queue pointers and slot counter
   ptr_type   high_head_ff, high_head_in, high_tail_ff, high_tail_in;
   ptr_type   low_head_ff, low_head_in, low_tail_ff, low_tail_in;
   cnt_type   high_count_ff, high_count_in, low_count_ff, low_count_in;
   stamp_type slot_ff, slot_in;

   // Result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [55:0] rsp_data_ff, rsp_data_in;
   logic [1:0]  rsp_user_ff, rsp_user_in;

   logic      accept, pop_high, pop_low, push_high, push_low, emit;
   stamp_type wait_full;
   arr_type   drop_high, drop_low;

   function automatic ptr_type ptr_next(input ptr_type p);
      return (p == ptr_type'(QUEUE_DEPTH - 1)) ? '0 : ptr_type'(p + 1'b1);
   endfunction

   function automatic arr_type arr_limit(input arr_type n);
      return (int'(n) > MAX_ARRIVALS) ? arr_type'(MAX_ARRIVALS) : n;
   endfunction

   function automatic logic [tcpqs_pkg::LEN_W-1:0] LEN_FIT(input cnt_type c);
      return tcpqs_pkg::LEN_W'(c);
   endfunction

   tcpqs_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ucode  (ucode)
   );

   // Decode the control word into datapath strobes
   always_comb begin
      req_tready = (ucode.action == tcpqs_pkg::ACT_LATCH);
      accept     = req_tvalid && req_tready;

      status.accept        = accept;
      status.can_push_high = (left_high_ff != '0) && (high_count_ff < cnt_type'(QUEUE_DEPTH));
      status.can_push_low  = (left_low_ff != '0) && (low_count_ff < cnt_type'(QUEUE_DEPTH));
      status.out_free      = !rsp_valid_ff || rsp_tready;

      // When the server is available, the high class takes it whenever its queue holds anyone
      pop_high  = (ucode.action == tcpqs_pkg::ACT_POP) && avail_ff && (high_count_ff != '0);
      pop_low   = (ucode.action == tcpqs_pkg::ACT_POP) && avail_ff && (high_count_ff == '0)
                  && (low_count_ff != '0);
      push_high = (ucode.action == tcpqs_pkg::ACT_PUSH_HIGH) && status.can_push_high;
      push_low  = (ucode.action == tcpqs_pkg::ACT_PUSH_LOW) && status.can_push_low;
      emit      = (ucode.action == tcpqs_pkg::ACT_EMIT) && status.out_free;
   end

   // Next values of the request, queue and slot registers
   always_comb begin
      avail_in       = avail_ff;
      arr_high_in    = arr_high_ff;
      arr_low_in     = arr_low_ff;
      left_high_in   = left_high_ff;
      left_low_in    = left_low_ff;
      pushed_high_in = pushed_high_ff;
      pushed_low_in  = pushed_low_ff;
      serve_high_in  = serve_high_ff;
      serve_low_in   = serve_low_ff;
      high_head_in   = high_head_ff;
      high_tail_in   = high_tail_ff;
      high_count_in  = high_count_ff;
      low_head_in    = low_head_ff;
      low_tail_in    = low_tail_ff;
      low_count_in   = low_count_ff;
      slot_in        = slot_ff;

      // Take a new slot and cap each arrival count
      if (accept) begin
         avail_in       = req_tdata[0];
         arr_high_in    = req_tdata[4:1];
         arr_low_in     = req_tdata[8:5];
         left_high_in   = arr_limit(req_tdata[4:1]);
         left_low_in    = arr_limit(req_tdata[8:5]);
         pushed_high_in = '0;
         pushed_low_in  = '0;
      end

      if (ucode.action == tcpqs_pkg::ACT_POP) begin
         serve_high_in = pop_high;
         serve_low_in  = pop_low;
      end
      if (pop_high) begin
         high_head_in  = ptr_next(high_head_ff);
         high_count_in = high_count_ff - 1'b1;
      end
      if (pop_low) begin
         low_head_in  = ptr_next(low_head_ff);
         low_count_in = low_count_ff - 1'b1;
      end

      if (push_high) begin
         high_tail_in   = ptr_next(high_tail_ff);
         high_count_in  = high_count_ff + 1'b1;
         left_high_in   = left_high_ff - 1'b1;
         pushed_high_in = pushed_high_ff + 1'b1;
      end
      if (push_low) begin
         low_tail_in   = ptr_next(low_tail_ff);
         low_count_in  = low_count_ff + 1'b1;
         left_low_in   = left_low_ff - 1'b1;
         pushed_low_in = pushed_low_ff + 1'b1;
      end

      // Advance the slot once its result is handed over
      if (emit) begin
         slot_in = slot_ff + 1'b1;
      end
   end

   // Assemble the result; the popped stamp still sits in its read register
   always_comb begin
      if (serve_high_ff) begin
         wait_full = slot_ff - high_q_ff;
      end else if (serve_low_ff) begin
         wait_full = slot_ff - low_q_ff;
      end else begin
         wait_full = '0;
      end
      drop_high = arr_high_ff - pushed_high_ff;
      drop_low  = arr_low_ff - pushed_low_ff;

      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {2'b00, drop_low, drop_high,
                         LEN_FIT(low_count_ff), LEN_FIT(high_count_ff),
                         tcpqs_pkg::WAIT_W'(wait_full)};
         rsp_user_in  = {serve_low_ff, serve_high_ff};
      end
   end

   // Stamp memories: one write and one registered read each
   always_ff @(posedge clock) begin
      if (push_high) begin
         high_mem[high_tail_ff] <= slot_ff;
      end
      if (pop_high) begin
         high_q_ff <= high_mem[high_head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (push_low) begin
         low_mem[low_tail_ff] <= slot_ff;
      end
      if (pop_low) begin
         low_q_ff <= low_mem[low_head_ff];
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      avail_ff       <= avail_in;
      arr_high_ff    <= arr_high_in;
      arr_low_ff     <= arr_low_in;
      left_high_ff   <= left_high_in;
      left_low_ff    <= left_low_in;
      pushed_high_ff <= pushed_high_in;
      pushed_low_ff  <= pushed_low_in;
      serve_high_ff  <= serve_high_in;
      serve_low_ff   <= serve_low_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_user_ff    <= rsp_user_in;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         high_head_ff  <= '0;
         high_tail_ff  <= '0;
         high_count_ff <= '0;
         low_head_ff   <= '0;
         low_tail_ff   <= '0;
         low_count_ff  <= '0;
         slot_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         high_head_ff  <= high_head_in;
         high_tail_ff  <= high_tail_in;
         high_count_ff <= high_count_in;
         low_head_ff   <= low_head_in;
         low_tail_ff   <= low_tail_in;
         low_count_ff  <= low_count_in;
         slot_ff       <= slot_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the two-class strict-priority queue server.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import tcpqs_pkg::*;

   localparam int DEPTH       = QUEUE_DEPTH_DEF;
   localparam int MAX_ARR     = MAX_ARRIVALS_DEF;
   localparam int TIME_W      = TIME_BITS_DEF;
   localparam int PTR_W       = $clog2(DEPTH);
   localparam int CLS_HIGH    = 0;
   localparam int CLS_LOW     = 1;
   localparam int SETTLE      = 40;      // a little over the longest slot
   localparam int HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT = 300000;

   typedef enum int {LOAD_BALANCED, LOAD_DRAIN, LOAD_BURST} load_mode_type;

   typedef struct packed {
      logic             available;
      logic [ARR_W-1:0] arrivals_high;
      logic [ARR_W-1:0] arrivals_low;
   } slot_request_type;

   typedef struct packed {
      logic              served_high;
      logic              served_low;
      logic [WAIT_W-1:0] wait_slots;
      logic [LEN_W-1:0]  length_high;
      logic [LEN_W-1:0]  length_low;
      logic [ARR_W-1:0]  dropped_high;
      logic [ARR_W-1:0]  dropped_low;
   } slot_result_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // [0] available, [4:1] arr high, [8:5] arr low
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;         // [31:0] wait, [38:32] len high, [45:39] len low,
                                   // [49:46] drop high, [53:50] drop low
   logic [1:0]  rsp_tuser;         // [0] served high, [1] served low

   // Mirror of the server: stamp stores, read pointers and fill levels per class
   logic [TIME_W-1:0] stamp_mem [2][DEPTH];
   logic [PTR_W-1:0]  read_ptr  [2] = '{default: '0};
   logic [LEN_W-1:0]  fill      [2] = '{default: '0};
   logic [TIME_W-1:0] slot_clock    = '0;

   slot_result_type expected_slots [$];
   int unsigned  mismatch_count = 0;
   int unsigned  cycle_count    = 0;
   int unsigned  send_idle_pct  = 0;
   int unsigned  recv_idle_pct  = 0;
   int unsigned  hold_requests  = 0;
   int unsigned  hold_seen      = 0;
   int unsigned  hold_left      = 0;

   two_class_priority_queue_server uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // Abandon the run if the block stops making progress
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Pop the oldest stamp of one class and return how long it has waited
   function automatic logic [TIME_W-1:0] pop_oldest(input int cls);
      logic [TIME_W-1:0] age;
      age = slot_clock - stamp_mem[cls][read_ptr[cls]];
      read_ptr[cls]++;
      fill[cls]--;
      return age;
   endfunction

   // Stamp as many arrivals as fit; return the number turned away
   function automatic logic [ARR_W-1:0] stamp_arrivals(input int cls, input int arrivals);
      int take;
      int room;
      take = arrivals > MAX_ARR ? MAX_ARR : arrivals;
      room = DEPTH - int'(fill[cls]);
      if (take > room) take = room;
      for (int i = 0; i < take; i++) begin
         stamp_mem[cls][read_ptr[cls] + PTR_W'(fill[cls])] = slot_clock;
         fill[cls]++;
      end
      return ARR_W'(arrivals - take);
   endfunction

   // Advance the mirror by one slot: serve, stamp arrivals, then tick the slot clock
   function automatic slot_result_type serve_and_stamp(input slot_request_type slot);
      slot_result_type res;
      res = '0;
      if (slot.available) begin
         if (fill[CLS_HIGH] != '0) begin
            res.wait_slots  = WAIT_W'(pop_oldest(CLS_HIGH));
            res.served_high = 1'b1;
         end else if (fill[CLS_LOW] != '0) begin
            res.wait_slots = WAIT_W'(pop_oldest(CLS_LOW));
            res.served_low = 1'b1;
         end
      end
      res.dropped_high = stamp_arrivals(CLS_HIGH, int'(slot.arrivals_high));
      res.dropped_low  = stamp_arrivals(CLS_LOW, int'(slot.arrivals_low));
      res.length_high  = fill[CLS_HIGH];
      res.length_low   = fill[CLS_LOW];
      slot_clock++;
      return res;
   endfunction

   task automatic check_field(input string name, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   task automatic check_result();
      slot_result_type got;
      slot_result_type want;
      got.served_high  = rsp_tuser[0];
      got.served_low   = rsp_tuser[1];
      got.wait_slots   = rsp_tdata[31:0];
      got.length_high  = rsp_tdata[38:32];
      got.length_low   = rsp_tdata[45:39];
      got.dropped_high = rsp_tdata[49:46];
      got.dropped_low  = rsp_tdata[53:50];
      if (expected_slots.size() == 0) begin
         mismatch_count++;
         $display("%0t: result with no slot outstanding, expected none, actual %h/%h",
                  $time, rsp_tuser, rsp_tdata);
      end else begin
         want = expected_slots.pop_front();
         check_field("served_high", 64'(want.served_high), 64'(got.served_high));
         check_field("served_low", 64'(want.served_low), 64'(got.served_low));
         check_field("wait_slots", 64'(want.wait_slots), 64'(got.wait_slots));
         check_field("length_high", 64'(want.length_high), 64'(got.length_high));
         check_field("length_low", 64'(want.length_low), 64'(got.length_low));
         check_field("dropped_high", 64'(want.dropped_high), 64'(got.dropped_high));
         check_field("dropped_low", 64'(want.dropped_low), 64'(got.dropped_low));
      end
   endtask

   // Result side: check each accepted transaction, then pick the next ready value.
   // A hold request blocks the channel for a long stretch counted here.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_result();
      if (hold_requests != hold_seen) begin
         hold_seen = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Offer one slot, idling first at random; keep valid high for a back-to-back slot
   task automatic send_slot(input logic avail, input logic [ARR_W-1:0] arr_high,
                            input logic [ARR_W-1:0] arr_low);
      slot_request_type slot;
      slot = '{available: avail, arrivals_high: arr_high, arrivals_low: arr_low};
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_tdata  <= {7'b0, arr_low, arr_high, avail};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      expected_slots.push_back(serve_and_stamp(slot));
   endtask

   // Drop valid and wait until every outstanding result has been checked
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_slots.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Walk through empty service, low service, priority, filling and overflow
   task automatic test_directed();
      send_slot(1'b0, 4'd0, 4'd0);     // nothing queued, server off
      send_slot(1'b1, 4'd0, 4'd0);     // server on but both queues empty
      send_slot(1'b0, 4'd0, 4'd5);
      send_slot(1'b1, 4'd0, 4'd0);     // low served while high is empty
      send_slot(1'b1, 4'd15, 4'd15);
      send_slot(1'b1, 4'd0, 4'd0);     // high now takes priority
      repeat (5) send_slot(1'b0, 4'd15, 4'd15);   // fill both queues and overflow
      send_slot(1'b1, 4'd15, 4'd15);   // one slot freed, the rest dropped
      send_slot(1'b0, 4'd1, 4'd0);
      send_slot(1'b1, 4'd8, 4'd9);
      send_slot(1'b0, 4'd10, 4'd6);
      send_slot(1'b1, 4'd1, 4'd2);
      send_slot(1'b1, 4'd4, 4'd8);
      send_slot(1'b0, 4'd2, 4'd4);
      drain();
   endtask

   // Random slots in stretches of burst, drain and balanced load so both
   // queues swing between empty and full
   task automatic test_random_load(input int count);
      load_mode_type    mode;
      int               mode_left;
      logic             avail;
      logic [ARR_W-1:0] arr_high;
      logic [ARR_W-1:0] arr_low;
      mode_left = 0;
      mode      = LOAD_BALANCED;
      repeat (count) begin
         if (mode_left == 0) begin
            mode      = load_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(16, 64);
         end
         mode_left--;
         case (mode)
            LOAD_BURST: begin
               avail    = 1'($urandom_range(0, 1));
               arr_high = ARR_W'($urandom_range(0, 15));
               arr_low  = ARR_W'($urandom_range(0, 15));
            end
            LOAD_DRAIN: begin
               avail    = ($urandom_range(0, 99) < 95);
               arr_high = ARR_W'($urandom_range(0, 99) < 5);
               arr_low  = ARR_W'($urandom_range(0, 99) < 5);
            end
            default: begin
               avail    = ($urandom_range(0, 99) < 85);
               arr_high = ($urandom_range(0, 99) < 30) ? ARR_W'($urandom_range(1, 2)) : '0;
               arr_low  = ($urandom_range(0, 99) < 30) ? ARR_W'($urandom_range(1, 3)) : '0;
            end
         endcase
         send_slot(avail, arr_high, arr_low);
      end
      drain();
   endtask

   // Block the result channel for a long stretch while slots keep coming,
   // so the output register fills and the input stalls
   task automatic test_output_backpressure();
      hold_requests <= hold_requests + 1;
      repeat (16) send_slot(1'($urandom_range(0, 1)), ARR_W'($urandom_range(0, 3)),
                            ARR_W'($urandom_range(0, 3)));
      drain();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();

      send_idle_pct = 36;
      recv_idle_pct <= 87;
      test_random_load(175);

      send_idle_pct = 87;
      recv_idle_pct <= 36;
      test_random_load(175);

      send_idle_pct = 0;
      recv_idle_pct <= 0;
      test_random_load(175);

      test_output_backpressure();

      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
design/tcpqs_pkg.sv
design/tcpqs_sequencer.sv
design/two_class_priority_queue_server.sv
sim/testbench.sv
